[rtl/core/sqft_pkg.sv]
// sqft_pkg: command and status bundles shared by the squarefree test
// controller, datapath and top level. No dependencies.
`default_nettype none
package sqft_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture a new request value
    logic div_start;   // begin a division of the numerator by d
    logic div_sel_q;   // numerator is the last quotient (else the remainder)
    logic div_step;    // one restoring division step
    logic next_d;      // advance to the next odd divisor
    logic take_q;      // remainder takes the saved quotient
    logic sqrt_start;  // begin the square root of the remainder
    logic sqrt_step;   // one square root digit step
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mult4;       // value is a multiple of 4
    logic d_ok;        // d cubed does not exceed the odd part of value
    logic div_done;    // division finished
    logic div_zero;    // division left no remainder
    logic rem_le1;     // remainder is 0 or 1
    logic sqrt_done;   // square root finished
    logic sqrt_exact;  // remainder is a perfect square
  } status_t;

endpackage
`default_nettype wire

[rtl/core/sqft_datapath.sv]
// sqft_datapath: remainder, divisor with its square and cube, a shared
// restoring divider and a digit-by-digit square root. Uses sqft_pkg.
`default_nettype none
module sqft_datapath #(
  parameter int WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic [WIDTH-1:0]  value,
  input  wire sqft_pkg::cmd_t    cmd,
  output sqft_pkg::status_t      status
);

  localparam int DW = WIDTH + 3;
  localparam int SW = WIDTH + (WIDTH % 2);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] rem0;
  logic             mult4;
  logic [DW-1:0]    d;
  logic [DW-1:0]    d2;
  logic [DW-1:0]    d3;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] qn;
  logic [WIDTH-1:0] qsave;
  logic [CW-1:0]    cnt;
  logic [SW-1:0]    sx;
  logic [SW-1:0]    sres;
  logic [SW-1:0]    sbit;

  // Divider step; the difference is only used when it fits in WIDTH bits
  logic [WIDTH:0]   rs;
  logic [WIDTH-1:0] rdiff;
  logic             rge;
  assign rs    = {acc, qn[WIDTH-1]};
  assign rdiff = rs[WIDTH-1:0] - d[WIDTH-1:0];
  assign rge   = (rs >= {1'b0, d[WIDTH-1:0]});

  // Square root step
  logic [SW-1:0]    ssum;
  assign ssum = sres + sbit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem   <= value[0] ? value : (value >> 1);
      rem0  <= value[0] ? value : (value >> 1);
      mult4 <= (value[1:0] == 2'b00);
      d     <= DW'(3);
      d2    <= DW'(9);
      d3    <= DW'(27);
    end else begin
      if (cmd.take_q) begin
        rem <= qsave;
      end
      // (d+2)^2 = d^2+4d+4, (d+2)^3 = d^3+6d^2+12d+8
      if (cmd.next_d) begin
        d  <= d + DW'(2);
        d2 <= d2 + (d << 2) + DW'(4);
        d3 <= d3 + (d2 << 2) + (d2 << 1) + (d << 3) + (d << 2) + DW'(8);
      end
    end

    // Restoring divider, one quotient bit a cycle
    if (cmd.div_start) begin
      acc <= '0;
      cnt <= '0;
      if (cmd.div_sel_q) begin
        qsave <= qn;
      end else begin
        qn <= rem;
      end
    end else if (cmd.div_step) begin
      cnt <= cnt + CW'(1);
      if (rge) begin
        acc <= rdiff;
        qn  <= {qn[WIDTH-2:0], 1'b1};
      end else begin
        acc <= rs[WIDTH-1:0];
        qn  <= {qn[WIDTH-2:0], 1'b0};
      end
    end

    // Square root, two bits of the radicand a cycle
    if (cmd.sqrt_start) begin
      sx   <= SW'(rem);
      sres <= '0;
      sbit <= SW'(1) << (SW - 2);
    end else if (cmd.sqrt_step) begin
      if (sx >= ssum) begin
        sx   <= sx - ssum;
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
      sbit <= sbit >> 2;
    end
  end

  assign status.mult4      = mult4;
  assign status.d_ok       = (d3 <= DW'(rem0));
  assign status.div_done   = (cnt == CW'(WIDTH));
  assign status.div_zero   = (acc == '0);
  assign status.rem_le1    = (rem <= WIDTH'(1));
  assign status.sqrt_done  = (sbit == '0);
  assign status.sqrt_exact = (sx == '0);

endmodule
`default_nettype wire

[rtl/core/sqft_ctrl.sv]
// sqft_ctrl: sequencer for the squarefree test: handshakes, trial division
// loop and final square check. Uses sqft_pkg.
`default_nettype none
module sqft_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   is_squarefree,
  output sqft_pkg::cmd_t         cmd,
  input  wire sqft_pkg::status_t status
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIV1, S_DIV2, S_FIN, S_SQRT, S_DONE
  } state_t;

  state_t state;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  // Command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load = in_valid;
      S_CHECK: cmd.div_start = !status.mult4 && status.d_ok;
      S_DIV1: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else if (status.div_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_sel_q = 1'b1;
        end else begin
          cmd.next_d = 1'b1;
        end
      end
      S_DIV2: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else if (!status.div_zero) begin
          cmd.take_q = 1'b1;
          cmd.next_d = 1'b1;
        end
      end
      S_FIN:   cmd.sqrt_start = !status.rem_le1;
      S_SQRT:  cmd.sqrt_step = !status.sqrt_done;
      S_DONE:  cmd = '0;
      default: cmd = '0;
    endcase
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      is_squarefree <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_CHECK;
        S_CHECK: begin
          if (status.mult4) begin
            is_squarefree <= 1'b0;
            state         <= S_DONE;
          end else if (status.d_ok) begin
            state <= S_DIV1;
          end else begin
            state <= S_FIN;
          end
        end
        S_DIV1: begin
          if (status.div_done) begin
            state <= status.div_zero ? S_DIV2 : S_CHECK;
          end
        end
        S_DIV2: begin
          if (status.div_done) begin
            if (status.div_zero) begin
              // d squared divides the remainder
              is_squarefree <= 1'b0;
              state         <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_FIN: begin
          if (status.rem_le1) begin
            is_squarefree <= 1'b1;
            state         <= S_DONE;
          end else begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (status.sqrt_done) begin
            is_squarefree <= !status.sqrt_exact;
            state         <= S_DONE;
          end
        end
        S_DONE: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/squarefree_test_core.sv]
// squarefree_test_core: top level of the squarefree test.
// Instantiates sqft_ctrl and sqft_datapath; uses sqft_pkg.
`default_nettype none
// Tests one unsigned WIDTH-bit value per request and returns one bit that is
// 1 when no prime square divides it. Requests are handled one at a time:
// in_stall is high from acceptance until the result has been taken. Odd
// divisors d from 3 up to the cube root of the odd part are tried through a
// single bit-serial restoring divider; a divisor that divides the remainder
// is tried once more on the quotient. A final square check follows, and the
// worst case is set by the divider loop.
module squarefree_test_core #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [WIDTH-1:0] value,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  is_squarefree
);

  sqft_pkg::cmd_t    cmd;
  sqft_pkg::status_t status;

  sqft_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_squarefree (is_squarefree),
    .cmd           (cmd),
    .status        (status)
  );

  sqft_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk    (clk),
    .value  (value),
    .cmd    (cmd),
    .status (status)
  );

endmodule
`default_nettype wire
